// ----- rtl/blts_pkg.sv -----
// shared types and constants for the banded lower-triangular solver
`default_nettype none

package blts_pkg;

  localparam int DATA_W       = 32;
  localparam int ACC_W        = 64;
  localparam int OFF_W        = 4;
  localparam int BW_W         = 5;
  localparam int BAND_MAX_DEF = 16;
  // deepest window entry a 4-bit offset can reach
  localparam int WIN_REACH    = 15;
  localparam int DIV_STEPS    = 32;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  localparam logic [BW_W-1:0]   BW_RESET = BW_W'(16);
  localparam logic [DATA_W-1:0] SAT_POS  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_NEG  = 32'h8000_0000;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic num;
    logic mag;
    logic prep;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic diag;
    logic skip_div;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/blts_item_if.sv -----
// input channel: one band coefficient per beat
`default_nettype none

interface blts_item_if;
  import blts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] coefficient;
  logic signed [DATA_W-1:0] rhs_value;
  logic [OFF_W-1:0]         band_offset;
  logic                     new_system;
  logic                     final_row;

  modport source (
    output valid, coefficient, rhs_value, band_offset, new_system, final_row,
    input  ready
  );

  modport sink (
    input  valid, coefficient, rhs_value, band_offset, new_system, final_row,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/blts_result_if.sv -----
// output channel: one solved unknown per beat
`default_nettype none

interface blts_result_if;
  import blts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] solution;
  logic                     last_of_system;
  logic                     divide_by_zero;
  logic                     overflow;

  modport source (
    output valid, solution, last_of_system, divide_by_zero, overflow,
    input  ready
  );

  modport sink (
    input  valid, solution, last_of_system, divide_by_zero, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/blts_datapath.sv -----
// solver datapath: window, multiply-accumulate, radix-2 divider, output register
`default_nettype none

module blts_datapath #(
  parameter int BAND_MAX = blts_pkg::BAND_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire blts_pkg::cmd_t                   cmd,
  output blts_pkg::status_t                     status,
  input  wire logic                             bandwidth_we,
  input  wire logic [blts_pkg::BW_W-1:0]        bandwidth_wdata,
  input  wire logic signed [blts_pkg::DATA_W-1:0] coefficient,
  input  wire logic signed [blts_pkg::DATA_W-1:0] rhs_value,
  input  wire logic [blts_pkg::OFF_W-1:0]       band_offset,
  input  wire logic                             new_system,
  input  wire logic                             final_row,
  input  wire logic                             result_ready,
  output logic                                  result_valid,
  output logic signed [blts_pkg::DATA_W-1:0]    solution,
  output logic                                  last_of_system,
  output logic                                  divide_by_zero,
  output logic                                  overflow
);
  import blts_pkg::*;

  localparam int WD    = (BAND_MAX - 1 < WIN_REACH) ? BAND_MAX - 1 : WIN_REACH;
  localparam int IDX_W = (WD > 1) ? $clog2(WD) : 1;
  localparam logic [6:0] BAND_LIM = 7'(BAND_MAX);
  localparam logic [6:0] WD_LIM   = 7'(WD);

  logic [BW_W-1:0]          bandwidth;
  logic signed [DATA_W-1:0] window [WD];
  logic signed [DATA_W-1:0] coef_r;
  logic signed [DATA_W-1:0] rhs_r;
  logic [OFF_W-1:0]         off_r;
  logic                     fin_r;
  logic                     use_term;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     sticky;
  logic [ACC_W-1:0]         num_r;
  logic                     ov_r;
  logic                     nneg;
  logic                     dneg;
  logic                     dz_r;
  logic                     big_r;
  logic [ACC_W-1:0]         nmag;
  logic [DATA_W-1:0]        dmag;
  logic [DATA_W-1:0]        rem;
  logic [DATA_W-1:0]        qbits;

  // effective bandwidth and term selection at the input beat
  logic [6:0]       bw_ext;
  logic [6:0]       bw_eff;
  logic [6:0]       off_ext;
  logic             term_ok;
  logic [OFF_W-1:0] off_m1;
  logic [IDX_W-1:0] rd_idx;
  logic signed [DATA_W-1:0] x_sel;

  always_comb begin
    bw_ext  = {2'b00, bandwidth};
    off_ext = {3'b000, band_offset};
    if (bw_ext == 7'd0) begin
      bw_eff = 7'd1;
    end else if (bw_ext > BAND_LIM) begin
      bw_eff = BAND_LIM;
    end else begin
      bw_eff = bw_ext;
    end
    term_ok = (band_offset != '0) && (off_ext < bw_eff) && (off_ext <= WD_LIM);
    off_m1  = off_r - OFF_W'(1);
    rd_idx  = off_m1[IDX_W-1:0];
    x_sel   = '0;
    if (use_term) begin
      x_sel = window[rd_idx];
    end
  end

  // saturating accumulate
  logic signed [ACC_W-1:0] sum;
  logic                    sum_ov;
  logic signed [ACC_W-1:0] sum_sat;

  always_comb begin
    sum     = acc + prod;
    sum_ov  = (acc[ACC_W-1] == prod[ACC_W-1]) && (sum[ACC_W-1] != acc[ACC_W-1]);
    sum_sat = sum;
    if (sum_ov) begin
      sum_sat = acc[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // saturating numerator: rhs widened to q32.32 minus accumulator
  logic [ACC_W-1:0] rhs_ext;
  logic [ACC_W-1:0] diff;
  logic             diff_ov;
  logic [ACC_W-1:0] diff_sat;

  always_comb begin
    rhs_ext  = {{16{rhs_r[DATA_W-1]}}, rhs_r, 16'h0000};
    diff     = rhs_ext - acc;
    diff_ov  = (rhs_ext[ACC_W-1] != acc[ACC_W-1]) &&
               (diff[ACC_W-1] != rhs_ext[ACC_W-1]);
    diff_sat = diff;
    if (diff_ov) begin
      diff_sat = rhs_ext[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} :
                                    {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // one quotient bit per step; remainder always stays below the divisor
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_sub;
  logic              trial_ge;
  logic [DATA_W-1:0] rem_next;
  logic              big_now;

  always_comb begin
    trial     = {rem, qbits[DATA_W-1]};
    trial_sub = trial - {1'b0, dmag};
    trial_ge  = trial >= {1'b0, dmag};
    rem_next  = trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
    big_now   = nmag[ACC_W-1:DATA_W] >= dmag;
  end

  // result forming with saturation
  logic [DATA_W-1:0] sol;
  logic              sol_ov;

  always_comb begin
    sol    = '0;
    sol_ov = ov_r;
    if (dz_r) begin
      sol = nneg ? SAT_NEG : SAT_POS;
    end else if (big_r) begin
      sol    = (nneg != dneg) ? SAT_NEG : SAT_POS;
      sol_ov = 1'b1;
    end else if (nneg != dneg) begin
      if (qbits > SAT_NEG) begin
        sol    = SAT_NEG;
        sol_ov = 1'b1;
      end else begin
        sol = DATA_W'(0) - qbits;
      end
    end else begin
      if (qbits > SAT_POS) begin
        sol    = SAT_POS;
        sol_ov = 1'b1;
      end else begin
        sol = qbits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bandwidth <= BW_RESET;
    end else if (bandwidth_we) begin
      bandwidth <= bandwidth_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      sticky <= 1'b0;
      for (int i = 0; i < WD; i++) begin
        window[i] <= '0;
      end
    end else begin
      if (cmd.load && new_system) begin
        acc    <= '0;
        sticky <= 1'b0;
        for (int i = 0; i < WD; i++) begin
          window[i] <= '0;
        end
      end
      if (cmd.acc && use_term) begin
        acc <= sum_sat;
        if (sum_ov) begin
          sticky <= 1'b1;
        end
      end
      if (cmd.finish) begin
        acc    <= '0;
        sticky <= 1'b0;
        for (int i = WD - 1; i > 0; i--) begin
          window[i] <= window[i-1];
        end
        window[0] <= sol;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coef_r   <= coefficient;
      rhs_r    <= rhs_value;
      off_r    <= band_offset;
      fin_r    <= final_row;
      use_term <= term_ok;
    end
    if (cmd.mul) begin
      prod <= coef_r * x_sel;
    end
    if (cmd.num) begin
      num_r <= diff_sat;
      ov_r  <= sticky | diff_ov;
    end
    if (cmd.mag) begin
      nneg <= num_r[ACC_W-1];
      nmag <= num_r[ACC_W-1] ? (ACC_W'(0) - num_r) : num_r;
      dneg <= coef_r[DATA_W-1];
      dmag <= coef_r[DATA_W-1] ? (DATA_W'(0) - coef_r) : coef_r;
      dz_r <= (coef_r == '0);
    end
    if (cmd.prep) begin
      big_r <= big_now;
      rem   <= nmag[ACC_W-1:DATA_W];
      qbits <= nmag[DATA_W-1:0];
    end
    if (cmd.div_step) begin
      rem   <= rem_next;
      qbits <= {qbits[DATA_W-2:0], trial_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      solution       <= sol;
      last_of_system <= fin_r;
      divide_by_zero <= dz_r;
      overflow       <= sol_ov;
    end
  end

  always_comb begin
    status.diag     = (band_offset == '0);
    status.skip_div = dz_r || big_now;
    status.out_free = !result_valid || result_ready;
  end

endmodule

`default_nettype wire

// ----- rtl/blts_ctrl.sv -----
// solver sequencer: steps each beat through multiply-accumulate or divide
`default_nettype none

module blts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire blts_pkg::status_t status,
  output blts_pkg::cmd_t         cmd
);
  import blts_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_NUM  = 3'd3;
  localparam logic [2:0] ST_MAG  = 3'd4;
  localparam logic [2:0] ST_PREP = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = status.diag ? ST_NUM : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_NUM: begin
        cmd.num    = 1'b1;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = status.skip_div ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold the result until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.acc, cmd.num, cmd.mag, cmd.prep,
              cmd.div_step, cmd.finish}))
    else $error("more than one datapath command at once");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result written while output register is full");

  a_offdiag_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !status.diag |=> cmd.mul ##1 cmd.acc)
    else $error("off-diagonal beat did not multiply then accumulate");

  a_div_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.prep && !status.skip_div |=> cmd.div_step)
    else $error("divider did not start after preparation");

endmodule

`default_nettype wire

// ----- rtl/banded_lower_triangular_solve.sv -----
// banded lower-triangular forward substitution, top level
// Usage: each row of the system arrives on the item channel as its
// off-diagonal band coefficients (band_offset 1..15), then one diagonal
// beat (band_offset 0) that carries rhs_value. new_system on a beat clears
// the solution window and the row accumulator first. Only the diagonal
// beat produces a result beat on the result channel.
// Timing: an off-diagonal beat passes through accept, 32x32 multiply and
// 64-bit saturating add. A diagonal beat passes through accept,
// numerator, magnitudes, divider setup, 32 radix-2 divider steps and
// the saturating result stage that loads the result register; a zero
// diagonal or a quotient of 2^32 or more skips the steps. Item ready
// is high only while idle, so a beat is finished before the next is taken.
// bandwidth is written through bandwidth_we / bandwidth_wdata; the user
// must write it only while idle; the block does not enforce this.
// Reset (rst, synchronous) clears the window, accumulator and flags,
// sets bandwidth to 16 and empties the result register. A stalled
// receiver holds the result; the block still takes off-diagonal beats
// and computes the next quotient, then waits before overwriting it.
`default_nettype none

module banded_lower_triangular_solve #(
  parameter int BAND_MAX = blts_pkg::BAND_MAX_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      bandwidth_we,
  input  wire logic [blts_pkg::BW_W-1:0] bandwidth_wdata,
  blts_item_if.sink                      item,
  blts_result_if.source                  result
);
  import blts_pkg::*;

  cmd_t    cmd;
  status_t status;

  blts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  blts_datapath #(
    .BAND_MAX (BAND_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .bandwidth_we    (bandwidth_we),
    .bandwidth_wdata (bandwidth_wdata),
    .coefficient     (item.coefficient),
    .rhs_value       (item.rhs_value),
    .band_offset     (item.band_offset),
    .new_system      (item.new_system),
    .final_row       (item.final_row),
    .result_ready    (result.ready),
    .result_valid    (result.valid),
    .solution        (result.solution),
    .last_of_system  (result.last_of_system),
    .divide_by_zero  (result.divide_by_zero),
    .overflow        (result.overflow)
  );

endmodule

`default_nettype wire
